// ===== hdl/rvaa_pkg.sv =====
// Package for the Rodrigues rotation core: fixed-point constants, the
// CORDIC arctangent table and the sideband struct carried down the pipeline.
// No dependencies.
package rvaa_pkg;

	localparam int CORDIC_STEPS = 18;

	// Q16.16 degrees
	localparam logic [32:0] DEG_FULL    = 33'd23592960;
	localparam logic [24:0] DEG_HALF    = 25'd11796480;
	localparam logic [23:0] DEG_QUARTER = 24'd5898240;
	// offset that makes any 32-bit angle non-negative before reduction
	localparam logic [32:0] DEG_OFFSET  = 33'd2170552320;
	localparam int          RED_STEPS   = 8;

	localparam logic [26:0] RAD_PER_DEG_Q32 = 27'd74961321;
	localparam logic signed [33:0] INV_GAIN_Q30 = 34'sd652032874;
	localparam logic signed [25:0] ONE_Q24 = 26'sd16777216;

	typedef struct packed {
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [31:0] rz;
		logic signed [17:0] nx;
		logic signed [17:0] ny;
		logic signed [17:0] nz;
		logic signed [33:0] dot;
		logic signed [33:0] crx;
		logic signed [33:0] cry;
		logic signed [33:0] crz;
		logic               half;
		logic               flip;
		logic               neg;
	} side_t;

	function automatic logic [29:0] atan_q30(input logic [4:0] idx);
		logic [29:0] v;
		case (idx)
			5'd0:  v = 30'd843314857;
			5'd1:  v = 30'd497837829;
			5'd2:  v = 30'd263043837;
			5'd3:  v = 30'd133525159;
			5'd4:  v = 30'd67021687;
			5'd5:  v = 30'd33543516;
			5'd6:  v = 30'd16775851;
			5'd7:  v = 30'd8388437;
			5'd8:  v = 30'd4194283;
			5'd9:  v = 30'd2097149;
			5'd31: v = 30'd0;
			default: v = 30'd1 << (5'd30 - idx);
		endcase
		return v;
	endfunction

endpackage

// ===== hdl/rvaa_prep.sv =====
// Front of the pipeline: angle reduction and fold to [0,90] degrees,
// degree-to-radian scaling, dot and cross products. Uses rvaa_pkg.
module rvaa_prep import rvaa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid_in,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic signed [17:0] axis_x,
	input  logic signed [17:0] axis_y,
	input  logic signed [17:0] axis_z,
	input  logic signed [31:0] angle_deg,
	output logic               valid_out,
	output logic signed [32:0] z_out,
	output side_t              side_out
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic [32:0] u_s1;
	logic [24:0] m_s2;
	logic [22:0] t_s3;
	logic [31:0] z_s4;
	side_t sd_s1, sd_s2, sd_s3, sd_s4;
	logic signed [49:0] pd_s1 [3];
	logic signed [49:0] pc_s1 [6];

	logic [32:0] u_hi, u_lo, u_init;
	logic signed [51:0] dot_sum;
	logic signed [50:0] cx_d, cy_d, cz_d;
	logic signed [51:0] dot_r;
	logic signed [50:0] cx_r, cy_r, cz_r;
	logic signed [25:0] mm;
	logic [23:0] t_abs;
	logic [49:0] zprod;
	logic [49:0] zrnd;
	side_t sd_n1, sd_n2, sd_n3;

	// subtract 2^j full turns: high half of the steps on the input angle, low half on u_s1
	always_comb begin
		u_init = 33'($signed({angle_deg[31], angle_deg})) + DEG_OFFSET;
		u_hi = u_init;
		for (int j = RED_STEPS - 1; j >= RED_STEPS / 2; j--) begin
			if (u_hi >= (DEG_FULL << j))
				u_hi = u_hi - (DEG_FULL << j);
		end
		u_lo = u_s1;
		for (int j = RED_STEPS / 2 - 1; j >= 0; j--) begin
			if (u_lo >= (DEG_FULL << j))
				u_lo = u_lo - (DEG_FULL << j);
		end
	end

	always_comb begin
		sd_n1 = '0;
		sd_n1.rx = point_x;
		sd_n1.ry = point_y;
		sd_n1.rz = point_z;
		sd_n1.nx = axis_x;
		sd_n1.ny = axis_y;
		sd_n1.nz = axis_z;
	end

	always_comb begin
		dot_sum = 52'(pd_s1[0]) + 52'(pd_s1[1]) + 52'(pd_s1[2]);
		cx_d = 51'(pc_s1[0]) - 51'(pc_s1[1]);
		cy_d = 51'(pc_s1[2]) - 51'(pc_s1[3]);
		cz_d = 51'(pc_s1[4]) - 51'(pc_s1[5]);
		dot_r = (dot_sum + 52'sd32768) >>> 16;
		cx_r = (cx_d + 51'sd32768) >>> 16;
		cy_r = (cy_d + 51'sd32768) >>> 16;
		cz_r = (cz_d + 51'sd32768) >>> 16;
		sd_n2 = sd_s1;
		sd_n2.dot = dot_r[33:0];
		sd_n2.crx = cx_r[33:0];
		sd_n2.cry = cy_r[33:0];
		sd_n2.crz = cz_r[33:0];
	end

	// fold to [-180,180), then to [0,90]
	always_comb begin
		if (m_s2 >= DEG_HALF)
			mm = $signed({1'b0, m_s2}) - $signed(26'(DEG_FULL));
		else
			mm = $signed({1'b0, m_s2});
		t_abs = mm[25] ? 24'(-mm) : 24'(mm);
		sd_n3 = sd_s2;
		sd_n3.half = (m_s2 == DEG_HALF);
		sd_n3.neg = mm[25];
		sd_n3.flip = (t_abs > DEG_QUARTER);
	end

	always_comb begin
		zprod = 50'(t_s3) * 50'(RAD_PER_DEG_Q32);
		zrnd = (zprod + 50'd131072) >> 18;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1 <= u_hi;
			sd_s1 <= sd_n1;
			pd_s1[0] <= 50'(point_x) * 50'(axis_x);
			pd_s1[1] <= 50'(point_y) * 50'(axis_y);
			pd_s1[2] <= 50'(point_z) * 50'(axis_z);
			pc_s1[0] <= 50'(axis_y) * 50'(point_z);
			pc_s1[1] <= 50'(axis_z) * 50'(point_y);
			pc_s1[2] <= 50'(axis_z) * 50'(point_x);
			pc_s1[3] <= 50'(axis_x) * 50'(point_z);
			pc_s1[4] <= 50'(axis_x) * 50'(point_y);
			pc_s1[5] <= 50'(axis_y) * 50'(point_x);

			m_s2 <= u_lo[24:0];
			sd_s2 <= sd_n2;

			sd_s3 <= sd_n3;
			if (t_abs > DEG_QUARTER)
				t_s3 <= 23'(24'(DEG_HALF) - t_abs);
			else
				t_s3 <= t_abs[22:0];

			sd_s4 <= sd_s3;
			z_s4 <= zrnd[31:0];
		end
	end

	assign valid_out = v_s4;
	assign z_out = $signed({1'b0, z_s4});
	assign side_out = sd_s4;

endmodule

// ===== hdl/rvaa_cordic_cell.sv =====
// One rotation-mode CORDIC iteration with its own register; the sideband
// rides along unchanged. Uses rvaa_pkg.
module rvaa_cordic_cell import rvaa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [4:0]         step_idx,
	input  logic               valid_in,
	input  logic signed [33:0] x_in,
	input  logic signed [33:0] y_in,
	input  logic signed [32:0] z_in,
	input  side_t              side_in,
	output logic               valid_out,
	output logic signed [33:0] x_out,
	output logic signed [33:0] y_out,
	output logic signed [32:0] z_out,
	output side_t              side_out
);

	logic valid_q;
	logic signed [33:0] x_q, y_q;
	logic signed [32:0] z_q;
	side_t side_q;

	logic signed [33:0] dx, dy;
	logic signed [32:0] da;

	assign dx = y_in >>> step_idx;
	assign dy = x_in >>> step_idx;
	assign da = $signed({3'b000, atan_q30(step_idx)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (en)
			valid_q <= valid_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_in;
			if (!z_in[32]) begin
				x_q <= x_in - dx;
				y_q <= y_in + dy;
				z_q <= z_in - da;
			end else begin
				x_q <= x_in + dx;
				y_q <= y_in - dy;
				z_q <= z_in + da;
			end
		end
	end

	assign valid_out = valid_q;
	assign x_out = x_q;
	assign y_out = y_q;
	assign z_out = z_q;
	assign side_out = side_q;

endmodule

// ===== hdl/rvaa_combine.sv =====
// Back of the pipeline: sin/cos rounding and sign restore, Rodrigues sum,
// rounding and saturation into the output register. Uses rvaa_pkg.
module rvaa_combine import rvaa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid_in,
	input  logic signed [33:0] x_in,
	input  logic signed [33:0] y_in,
	input  side_t              side_in,
	output logic               valid_out,
	output logic signed [31:0] rotated_x,
	output logic signed [31:0] rotated_y,
	output logic signed [31:0] rotated_z,
	output logic               overflow
);

	function automatic logic signed [25:0] q30_to_q24(input logic signed [33:0] v);
		logic signed [33:0] r;
		r = (v + 34'sd32) >>> 6;
		if (r > 34'(ONE_Q24))
			return ONE_Q24;
		else if (r < -34'(ONE_Q24))
			return -ONE_Q24;
		return r[25:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		if (v > 40'sh007fffffff)
			return 32'sh7fffffff;
		else if (v < -40'sh0080000000)
			return -32'sh80000000;
		return v[31:0];
	endfunction

	logic v_c1, v_c2, v_c3, v_c4, v_c5;
	logic signed [25:0] c_c1, s_c1;
	side_t sd_c1, sd_c2;
	logic signed [60:0] bp_c2;
	logic signed [57:0] crp_c2 [3];
	logic signed [59:0] srp_c2 [3];
	logic signed [57:0] crp_c3 [3];
	logic signed [59:0] srp_c3 [3];
	logic signed [54:0] bn_c3 [3];
	logic signed [63:0] acc_c4 [3];
	logic signed [31:0] q_c5 [3];
	logic ovf_c5;

	logic signed [25:0] cx, sy;
	logic signed [26:0] omc;
	logic signed [60:0] b_rnd;
	logic signed [36:0] b16;
	logic signed [31:0] rv [3];
	logic signed [17:0] nv [3];
	logic signed [33:0] cv [3];
	logic signed [39:0] qw [3];
	logic signed [39:0] qr [3];

	always_comb begin
		cx = q30_to_q24(x_in);
		sy = q30_to_q24(y_in);
		if (side_in.flip)
			cx = -cx;
		if (side_in.neg)
			sy = -sy;
		// half turn: exact cos -1, sin 0
		if (side_in.half) begin
			cx = -ONE_Q24;
			sy = '0;
		end
	end

	always_comb begin
		omc = 27'(ONE_Q24) - 27'(c_c1);
		rv[0] = sd_c1.rx;
		rv[1] = sd_c1.ry;
		rv[2] = sd_c1.rz;
		cv[0] = sd_c1.crx;
		cv[1] = sd_c1.cry;
		cv[2] = sd_c1.crz;
		nv[0] = sd_c2.nx;
		nv[1] = sd_c2.ny;
		nv[2] = sd_c2.nz;
		b_rnd = (bp_c2 + 61'sd8388608) >>> 24;
		b16 = b_rnd[36:0];
		for (int k = 0; k < 3; k++) begin
			qw[k] = 40'((acc_c4[k] + 64'sd8388608) >>> 24);
			qr[k] = qw[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c1 <= 1'b0;
			v_c2 <= 1'b0;
			v_c3 <= 1'b0;
			v_c4 <= 1'b0;
			v_c5 <= 1'b0;
		end else if (en) begin
			v_c1 <= valid_in;
			v_c2 <= v_c1;
			v_c3 <= v_c2;
			v_c4 <= v_c3;
			v_c5 <= v_c4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_c1 <= cx;
			s_c1 <= sy;
			sd_c1 <= side_in;

			sd_c2 <= sd_c1;
			bp_c2 <= 61'(sd_c1.dot) * 61'(omc);
			for (int k = 0; k < 3; k++) begin
				crp_c2[k] <= 58'(c_c1) * 58'(rv[k]);
				srp_c2[k] <= 60'(s_c1) * 60'(cv[k]);
			end

			for (int k = 0; k < 3; k++) begin
				crp_c3[k] <= crp_c2[k];
				srp_c3[k] <= srp_c2[k];
				bn_c3[k] <= 55'(b16) * 55'(nv[k]);
			end

			for (int k = 0; k < 3; k++)
				acc_c4[k] <= 64'(crp_c3[k]) + (64'(bn_c3[k]) <<< 8) + 64'(srp_c3[k]);

			for (int k = 0; k < 3; k++)
				q_c5[k] <= sat32(qr[k]);
			ovf_c5 <= (qr[0] > 40'sh007fffffff) || (qr[0] < -40'sh0080000000)
				|| (qr[1] > 40'sh007fffffff) || (qr[1] < -40'sh0080000000)
				|| (qr[2] > 40'sh007fffffff) || (qr[2] < -40'sh0080000000);
		end
	end

	assign valid_out = v_c5;
	assign rotated_x = q_c5[0];
	assign rotated_y = q_c5[1];
	assign rotated_z = q_c5[2];
	assign overflow = ovf_c5;

endmodule

// ===== hdl/rotate_vector_about_axis_core.sv =====
// Rodrigues rotation core: one transaction per cycle through a row of CORDIC cells
// and multiplier stages, as long as the pipeline advances.
// The whole pipeline advances while the output register is empty or being taken.
// arst_n clears all valid bits; data registers are not reset.
// Uses rvaa_pkg, rvaa_prep, rvaa_cordic_cell, rvaa_combine.
module rotate_vector_about_axis_core import rvaa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic signed [17:0] axis_x,
	input  logic signed [17:0] axis_y,
	input  logic signed [17:0] axis_z,
	input  logic signed [31:0] angle_deg,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] rotated_x,
	output logic signed [31:0] rotated_y,
	output logic signed [31:0] rotated_z,
	output logic               overflow
);

	logic en;
	logic               cv [CORDIC_STEPS + 1];
	logic signed [33:0] cxv [CORDIC_STEPS + 1];
	logic signed [33:0] cyv [CORDIC_STEPS + 1];
	logic signed [32:0] czv [CORDIC_STEPS + 1];
	side_t              csd [CORDIC_STEPS + 1];

	assign en = !out_valid || out_ready;
	assign in_ready = en;

	rvaa_prep u_prep (
		.clk(clk), .arst_n(arst_n), .en(en), .valid_in(in_valid),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
		.angle_deg(angle_deg),
		.valid_out(cv[0]), .z_out(czv[0]), .side_out(csd[0])
	);

	assign cxv[0] = INV_GAIN_Q30;
	assign cyv[0] = '0;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		rvaa_cordic_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .step_idx(5'(i)),
			.valid_in(cv[i]), .x_in(cxv[i]), .y_in(cyv[i]), .z_in(czv[i]),
			.side_in(csd[i]),
			.valid_out(cv[i+1]), .x_out(cxv[i+1]), .y_out(cyv[i+1]),
			.z_out(czv[i+1]), .side_out(csd[i+1])
		);
	end

	rvaa_combine u_comb (
		.clk(clk), .arst_n(arst_n), .en(en), .valid_in(cv[CORDIC_STEPS]),
		.x_in(cxv[CORDIC_STEPS]), .y_in(cyv[CORDIC_STEPS]),
		.side_in(csd[CORDIC_STEPS]),
		.valid_out(out_valid), .rotated_x(rotated_x), .rotated_y(rotated_y),
		.rotated_z(rotated_z), .overflow(overflow)
	);

endmodule

// ===== hdl/rvaa_checker.sv =====
// Port-level checks for the rotation core, bound to the top level.
// Depends only on the ports of rotate_vector_about_axis_core.
module rvaa_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] rotated_x,
	input logic signed [31:0] rotated_y,
	input logic signed [31:0] rotated_z,
	input logic               overflow
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result shown during reset");

	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input stalled while output side free");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rotated_x)
		&& $stable(rotated_y) && $stable(rotated_z) && $stable(overflow))
		else $error("stalled result changed");

	a_ovf_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |->
		rotated_x == 32'sh7fffffff || rotated_x == -32'sh80000000 ||
		rotated_y == 32'sh7fffffff || rotated_y == -32'sh80000000 ||
		rotated_z == 32'sh7fffffff || rotated_z == -32'sh80000000)
		else $error("overflow flagged without saturated component");

endmodule

bind rotate_vector_about_axis_core rvaa_checker u_rvaa_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready), .out_valid(out_valid),
	.out_ready(out_ready), .rotated_x(rotated_x), .rotated_y(rotated_y),
	.rotated_z(rotated_z), .overflow(overflow)
);

// ===== tb/tb.sv =====
// Self-checking bench for rotate_vector_about_axis_core: Rodrigues rotation of a
// Q16.16 point with a bit-exact CORDIC predictor, random idles on both handshakes.
// Depends on rvaa_pkg and the core RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rvaa_pkg::*;

	typedef struct {
		logic signed [31:0] px, py, pz;
		logic signed [17:0] ax, ay, az;
		logic signed [31:0] ang;
	} rot_req_t;

	typedef struct {
		logic signed [31:0] qx, qy, qz;
		logic               ovf;
	} rot_res_t;

	localparam int   NUM_RANDOM = 1650;
	localparam int   MAX_CYCLES = 400000;
	localparam longint FULL_TURN = 64'sd23592960;
	localparam longint HALF_TURN = 64'sd11796480;
	localparam longint QTR_TURN  = 64'sd5898240;
	localparam longint UNIT_Q24  = 64'sd16777216;
	localparam longint ATAN_TBL [0:17] = '{843314857, 497837829, 263043837, 133525159,
		67021687, 33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
		262144, 131072, 65536, 32768, 16384, 8192};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] point_x = '0, point_y = '0, point_z = '0, angle_deg = '0;
	logic signed [17:0] axis_x = '0, axis_y = '0, axis_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] rotated_x, rotated_y, rotated_z;
	logic overflow;

	rot_req_t pending_q[$];
	rot_res_t rotated_q[$];
	int errors = 0;
	int cycle = 0;

	rotate_vector_about_axis_core DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint rnd_shift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clamp_unit(longint v);
		return v < -UNIT_Q24 ? -UNIT_Q24 : (v > UNIT_Q24 ? UNIT_Q24 : v);
	endfunction

	function automatic rot_res_t rotate_point(rot_req_t rq);
		rot_res_t   res;
		longint     r[3], n[3], cr[3];
		longint     m, t, z, x, y, dx, dy, c, s, dot16, b16, acc, q;
		bit         neg, flip;
		r[0] = rq.px; r[1] = rq.py; r[2] = rq.pz;
		n[0] = rq.ax; n[1] = rq.ay; n[2] = rq.az;
		m = longint'(rq.ang) % FULL_TURN;
		if (m < 0) m += FULL_TURN;
		if (m >= HALF_TURN) m -= FULL_TURN;
		if (m == -HALF_TURN) begin
			c = -UNIT_Q24;
			s = 0;
		end else begin
			neg = m < 0;
			t = neg ? -m : m;
			flip = t > QTR_TURN;
			if (flip) t = HALF_TURN - t;
			z = (t * 64'sd74961321 + (64'sd1 <<< 17)) >>> 18;
			x = 64'sd652032874;
			y = 0;
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= ATAN_TBL[i];
				end else begin
					x += dx; y -= dy; z += ATAN_TBL[i];
				end
			end
			c = clamp_unit(rnd_shift(x, 6));
			s = clamp_unit(rnd_shift(y, 6));
			if (flip) c = -c;
			if (neg) s = -s;
		end
		dot16 = rnd_shift(r[0] * n[0] + r[1] * n[1] + r[2] * n[2], 16);
		cr[0] = rnd_shift(n[1] * r[2] - n[2] * r[1], 16);
		cr[1] = rnd_shift(n[2] * r[0] - n[0] * r[2], 16);
		cr[2] = rnd_shift(n[0] * r[1] - n[1] * r[0], 16);
		b16 = rnd_shift(dot16 * (UNIT_Q24 - c), 24);
		res.ovf = 1'b0;
		for (int k = 0; k < 3; k++) begin
			acc = c * r[k] + (b16 * n[k]) * 256 + s * cr[k];
			q = rnd_shift(acc, 24);
			if (q > 64'sd2147483647) begin
				q = 64'sd2147483647; res.ovf = 1'b1;
			end else if (q < -64'sd2147483648) begin
				q = -64'sd2147483648; res.ovf = 1'b1;
			end
			if (k == 0) res.qx = q[31:0];
			else if (k == 1) res.qy = q[31:0];
			else res.qz = q[31:0];
		end
		return res;
	endfunction

	// no idling in a quiet window so back-to-back streaming is covered
	function automatic bit take_idle();
		if (cycle >= 400 && cycle < 1200) return 1'b0;
		return $urandom_range(0, 99) < 7;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rot_req_t rq;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				rotated_q.push_back(rotate_point('{point_x, point_y, point_z,
					axis_x, axis_y, axis_z, angle_deg}));
			if (!in_valid || in_ready) begin
				if (pending_q.size() > 0 && !take_idle()) begin
					rq = pending_q.pop_front();
					point_x <= rq.px; point_y <= rq.py; point_z <= rq.pz;
					axis_x <= rq.ax; axis_y <= rq.ay; axis_z <= rq.az;
					angle_deg <= rq.ang;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		rot_res_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			cycle <= cycle + 1;
			out_ready <= !take_idle();
			if (out_valid && out_ready) begin
				if (rotated_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected transaction at cycle %0d", cycle);
				end else begin
					want = rotated_q.pop_front();
					if (rotated_x !== want.qx || rotated_y !== want.qy ||
						rotated_z !== want.qz || overflow !== want.ovf) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp %0d %0d %0d ovf %0b got %0d %0d %0d ovf %0b",
								want.qx, want.qy, want.qz, want.ovf,
								rotated_x, rotated_y, rotated_z, overflow);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycle > MAX_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic signed [17:0] rand_axis();
		return 18'(int'($urandom_range(0, 131072)) - 65536);
	endfunction

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'(int'($urandom_range(0, 2097152)) - 1048576);
			default: return 32'(int'($urandom_range(0, 200000000)) - 100000000);
		endcase
	endfunction

	task automatic add_item(input int px, py, pz, ax, ay, az, ang);
		pending_q.push_back('{px, py, pz, 18'(ax), 18'(ay), 18'(az), ang});
	endtask

	initial begin
		rot_req_t rq;
		real vx, vy, vz, len;
		int ang_list [] = '{0, 180 << 16, -(180 << 16), 540 << 16, 90 << 16, -(90 << 16),
			270 << 16, 360 << 16, 45 << 16, 32'h7fffffff, 32'h80000000, 1, -1};
		foreach (ang_list[i])
			add_item(65536 * 3, -65536 * 2, 65536, 0, 0, 65536, ang_list[i]);
		// saturating: extreme points, unit and off-unit axes; then mid-range, tiny and zero points
		add_item(32'h7fffffff, 32'h7fffffff, 0, 0, 0, 65536, 45 << 16);
		add_item(32'h80000000, 32'h80000000, 32'h80000000, -65536, 0, 0, 30 << 16);
		add_item(32'h7fffffff, 32'h80000000, 32'h7fffffff, 65536, 65536, 65536, 180 << 16);
		add_item(32'h80000000, 32'h7fffffff, 32'h80000000, -65536, -65536, -65536,
			-(120 << 16));
		add_item(12345678, -87654321, 5555555, 0, -65536, 0, 77 << 16);
		add_item(-1, 1, 0, 37837, 37837, 37837, -(60 << 16));
		add_item(0, 0, 0, 65536, 0, 0, 123 << 16);
		repeat (NUM_RANDOM) begin
			rq.px = rand_coord(); rq.py = rand_coord(); rq.pz = rand_coord();
			case ($urandom_range(0, 3))
				0: begin
					rq.ax = rand_axis(); rq.ay = rand_axis(); rq.az = rand_axis();
				end
				1: begin
					rq.ax = 0; rq.ay = 0; rq.az = 0;
					case ($urandom_range(0, 2))
						0: rq.ax = $urandom_range(0, 1) ? 65536 : -65536;
						1: rq.ay = $urandom_range(0, 1) ? 65536 : -65536;
						default: rq.az = $urandom_range(0, 1) ? 65536 : -65536;
					endcase
				end
				default: begin
					vx = $itor(rand_axis()) + 0.5; vy = $itor(rand_axis());
					vz = $itor(rand_axis());
					len = $sqrt(vx * vx + vy * vy + vz * vz);
					rq.ax = $rtoi(vx * 65536.0 / len); rq.ay = $rtoi(vy * 65536.0 / len);
					rq.az = $rtoi(vz * 65536.0 / len);
				end
			endcase
			case ($urandom_range(0, 3))
				0: rq.ang = $urandom;
				1: rq.ang = (int'($urandom_range(0, 20)) - 10) * (180 << 16);
				default: rq.ang = int'($urandom_range(0, 47185920)) - 23592960;
			endcase
			pending_q.push_back(rq);
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_q.size() == 0);
		@(posedge clk);
		while (in_valid) @(posedge clk);
		while (rotated_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (out_valid) errors++;
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
